@@ hdl/fat_chain_manager_defines.svh @@
// ============================================================================
// fat_chain_manager_defines.svh
// Assertion macros shared by the link table manager.
// ============================================================================
`ifndef FAT_CHAIN_MANAGER_DEFINES_SVH
`define FAT_CHAIN_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset
`define FCM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset
`define FCM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fcm_pkg.sv @@
// ============================================================================
// fcm_pkg
// Sizes, codes and types for the file allocation table chain manager.
// ============================================================================
package fcm_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 4096;
    localparam int BLOCK_BYTES   = 4096;
    localparam int AW            = $clog2(TABLE_ENTRIES);
    localparam int SCAN_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int BLK_SH        = $clog2(BLOCK_BYTES);

    // Field widths
    localparam int LINK_W  = 16;
    localparam int DBC_W   = 13;
    localparam int FREE_W  = 13;
    localparam int REM_W   = 13;
    localparam int OFF_W   = 32;
    localparam int CMP_W   = 17;

    localparam logic [LINK_W-1:0] END_OF_CHAIN = 16'hFFFF;
    localparam logic [DBC_W-1:0]  DBC_RESET    = 13'd4096;

    // Command codes
    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_ALLOC  = 3'd1,
        ACT_EXTEND = 3'd2,
        ACT_FREE   = 3'd3,
        ACT_SEEK   = 3'd4
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_ENDED   = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // Register indexes on the APB port
    localparam logic REG_DBC = 1'b0;
    localparam logic REG_DSI = 1'b1;

endpackage

@@ hdl/fat_chain_manager.sv @@
// ============================================================================
// fat_chain_manager
// File allocation table of 16-bit links with load, allocate, extend, free and
// seek commands, one table read and one write port, run by a small sequencer.
// ============================================================================
//
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  ----------------------------------
//  command   in         i_valid / o_ready   action, block_index, entry_value,
//                                           byte_offset
//  result    out        o_valid / i_ready   status, result_block,
//                                           remaining_offset, free_blocks
//  config    in         APB psel/penable    data_block_count, data_start_index
//
//  After reset a clearing pass zeroes all TABLE_ENTRIES entries, one entry a
//  cycle; no command is taken meanwhile.
//  One command at a time, bound by the table's one read and one write port:
//  load reads then writes, allocate scans to the first free entry, extend
//  adds a tail read and a link write, free and seek walk the chain by link.
//  The first command after reset or a data_block_count write adds a recount
//  of the zero entries below min(data_block_count, 4096).
//  A finished result waits in the output register; the next command is
//  taken while it waits, and only the following result stalls on i_ready.
//
`include "fat_chain_manager_defines.svh"

module fat_chain_manager
    import fcm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command transaction
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_action,
    input  logic [LINK_W-1:0]    i_block_index,
    input  logic [LINK_W-1:0]    i_entry_value,
    input  logic [OFF_W-1:0]     i_byte_offset,
    // result transaction
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [LINK_W-1:0]    o_result_block,
    output logic [REM_W-1:0]     o_remaining_offset,
    output logic [FREE_W-1:0]    o_free_blocks,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RECOUNT,
        S_DISPATCH,
        S_LOAD_RD,
        S_LOAD_WR,
        S_SCAN,
        S_EXT_RD,
        S_EXT_CHK,
        S_EXT_LINK,
        S_ALLOC_WR,
        S_FREE_RD,
        S_FREE_WR,
        S_SEEK_RD,
        S_SEEK_CHK,
        S_RESP
    } t_state;

    t_state               r_state;

    // configuration registers
    logic [DBC_W-1:0]     r_dbc;
    logic [LINK_W-1:0]    r_dsi;
    logic                 r_dirty;

    // command being served
    t_action              r_action;
    logic [LINK_W-1:0]    r_cur;
    logic [LINK_W-1:0]    r_val;
    logic [OFF_W-1:0]     r_off;
    logic [SCAN_W-1:0]    r_steps;

    // scan pipeline
    logic [SCAN_W-1:0]    r_scan_addr;
    logic [AW-1:0]        r_chk;
    logic                 r_pend;
    logic [AW-1:0]        r_nb;

    logic [FREE_W-1:0]    r_free;
    logic [FREE_W-1:0]    n_free;

    // pending result
    t_status              r_res_status;
    logic [LINK_W-1:0]    r_res_block;
    logic [REM_W-1:0]     r_res_rem;

    // output register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [LINK_W-1:0]    r_out_block;
    logic [REM_W-1:0]     r_out_rem;
    logic [FREE_W-1:0]    r_out_free;

    // link table
    logic [LINK_W-1:0]    r_mem [TABLE_ENTRIES];
    logic [LINK_W-1:0]    r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [LINK_W-1:0]    mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [LINK_W-1:0]    mem_old;

    logic [SCAN_W-1:0]    lim;
    logic                 cur_oob;
    logic                 rdata_oob;
    logic                 seek_too_far;
    logic                 scan_hit;
    logic                 scan_end;
    logic                 wr_in_lim;
    logic                 cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_DSI) ? {16'b0, r_dsi} : {19'b0, r_dbc};

    // ------------------------------------------------------------------
    // Derived compares
    // ------------------------------------------------------------------
    assign lim = (CMP_W'(r_dbc) < CMP_W'(TABLE_ENTRIES)) ? SCAN_W'(r_dbc)
                                                         : SCAN_W'(TABLE_ENTRIES);
    assign cur_oob      = CMP_W'(r_cur) >= CMP_W'(TABLE_ENTRIES);
    assign rdata_oob    = CMP_W'(r_rdata) >= CMP_W'(TABLE_ENTRIES);
    assign seek_too_far = (r_off >> BLK_SH) > OFF_W'(TABLE_ENTRIES);
    assign scan_hit     = r_pend && (r_rdata == '0);
    assign scan_end     = r_scan_addr >= lim;

    assign o_ready = (r_state == S_IDLE);

    // ------------------------------------------------------------------
    // Table port control and free count adjust on each write
    // ------------------------------------------------------------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cur[AW-1:0];
        mem_wdata = '0;
        mem_raddr = r_cur[AW-1:0];
        mem_old   = r_rdata;
        unique case (r_state) inside
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_scan_addr[AW-1:0];
            end
            S_SCAN, S_RECOUNT: begin
                mem_raddr = r_scan_addr[AW-1:0];
            end
            S_LOAD_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_val;
            end
            S_EXT_LINK: begin
                mem_we    = 1'b1;
                mem_wdata = LINK_W'(r_nb);
                mem_old   = END_OF_CHAIN;
            end
            S_ALLOC_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_nb;
                mem_wdata = END_OF_CHAIN;
                mem_old   = '0;
            end
            S_FREE_WR: begin
                mem_we    = 1'b1;
            end
            default: begin
            end
        endcase

        wr_in_lim = CMP_W'(mem_waddr) < CMP_W'(lim);
        n_free    = r_free;
        if (wr_in_lim) begin
            if ((mem_old == '0) && (mem_wdata != '0)) begin
                n_free = r_free - FREE_W'(1);
            end else if ((mem_old != '0) && (mem_wdata == '0)) begin
                n_free = r_free + FREE_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Link table memory, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scan_addr <= '0;
            r_pend      <= 1'b0;
            r_dirty     <= 1'b1;
            r_dbc       <= DBC_RESET;
            r_dsi       <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr) begin
                if (paddr[2] == REG_DBC) begin
                    r_dbc   <= pwdata[DBC_W-1:0];
                    r_dirty <= 1'b1;
                end else begin
                    r_dsi   <= pwdata[LINK_W-1:0];
                end
            end

            // result taken downstream; the response step reloads it itself
            if (r_out_valid && i_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                // zero the table after reset
                S_CLEAR: begin
                    if (r_scan_addr == SCAN_W'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_scan_addr <= r_scan_addr + SCAN_W'(1);
                    end
                end

                S_IDLE: begin
                    if (i_valid) begin
                        r_action     <= t_action'(i_action);
                        r_cur        <= i_block_index;
                        r_val        <= i_entry_value;
                        r_off        <= i_byte_offset;
                        r_res_status <= ST_OK;
                        r_res_block  <= '0;
                        r_res_rem    <= '0;
                        r_scan_addr  <= '0;
                        r_pend       <= 1'b0;
                        if (r_dirty) begin
                            r_free  <= '0;
                            r_state <= S_RECOUNT;
                        end else begin
                            r_state <= S_DISPATCH;
                        end
                    end
                end

                // count zero entries below the limit
                S_RECOUNT: begin
                    if (scan_hit) begin
                        r_free <= r_free + FREE_W'(1);
                    end
                    if (scan_end) begin
                        r_dirty <= 1'b0;
                        r_state <= S_DISPATCH;
                    end else begin
                        r_chk       <= r_scan_addr[AW-1:0];
                        r_pend      <= 1'b1;
                        r_scan_addr <= r_scan_addr + SCAN_W'(1);
                    end
                end

                S_DISPATCH: begin
                    r_scan_addr <= '0;
                    r_pend      <= 1'b0;
                    r_steps     <= SCAN_W'(r_off >> BLK_SH);
                    unique case (r_action)
                        ACT_LOAD: begin
                            if (cur_oob) begin
                                r_res_status <= ST_RANGE;
                                r_state      <= S_RESP;
                            end else begin
                                r_state <= S_LOAD_RD;
                            end
                        end
                        ACT_ALLOC: begin
                            r_state <= S_SCAN;
                        end
                        ACT_EXTEND: begin
                            if (cur_oob) begin
                                r_res_status <= ST_RANGE;
                                r_state      <= S_RESP;
                            end else begin
                                r_state <= S_EXT_RD;
                            end
                        end
                        ACT_FREE: begin
                            r_state <= S_FREE_RD;
                        end
                        ACT_SEEK: begin
                            if (cur_oob) begin
                                r_res_status <= ST_RANGE;
                                r_state      <= S_RESP;
                            end else if (seek_too_far) begin
                                r_res_status <= ST_ENDED;
                                r_state      <= S_RESP;
                            end else begin
                                r_state <= S_SEEK_RD;
                            end
                        end
                        default: begin
                            r_state <= S_RESP;
                        end
                    endcase
                end

                // load: read old link, then write the new one
                S_LOAD_RD: begin
                    r_state <= S_LOAD_WR;
                end
                S_LOAD_WR: begin
                    r_free      <= n_free;
                    r_res_block <= r_cur;
                    r_state     <= S_RESP;
                end

                // first-fit search, one entry per cycle
                S_SCAN: begin
                    if (scan_hit) begin
                        r_nb        <= r_chk;
                        r_res_block <= LINK_W'(r_chk);
                        r_state     <= (r_action == ACT_EXTEND) ? S_EXT_LINK : S_ALLOC_WR;
                    end else if (scan_end) begin
                        r_res_status <= ST_NO_FREE;
                        r_state      <= S_RESP;
                    end else begin
                        r_chk       <= r_scan_addr[AW-1:0];
                        r_pend      <= 1'b1;
                        r_scan_addr <= r_scan_addr + SCAN_W'(1);
                    end
                end

                // extend: look at the tail link
                S_EXT_RD: begin
                    r_state <= S_EXT_CHK;
                end
                S_EXT_CHK: begin
                    if (r_rdata == END_OF_CHAIN) begin
                        r_state <= S_SCAN;
                    end else if (r_rdata == '0) begin
                        r_res_status <= ST_ENDED;
                        r_state      <= S_RESP;
                    end else begin
                        r_res_block <= r_rdata;
                        r_state     <= S_RESP;
                    end
                end
                S_EXT_LINK: begin
                    r_free  <= n_free;
                    r_state <= S_ALLOC_WR;
                end
                S_ALLOC_WR: begin
                    r_free  <= n_free;
                    r_state <= S_RESP;
                end

                // free: clear links along the chain
                S_FREE_RD: begin
                    if ((r_cur == END_OF_CHAIN) || (r_cur == '0)) begin
                        r_state <= S_RESP;
                    end else if (cur_oob) begin
                        r_res_status <= ST_RANGE;
                        r_state      <= S_RESP;
                    end else begin
                        r_state <= S_FREE_WR;
                    end
                end
                S_FREE_WR: begin
                    r_free  <= n_free;
                    r_cur   <= r_rdata;
                    r_state <= S_FREE_RD;
                end

                // seek: one link per step
                S_SEEK_RD: begin
                    if (r_steps == '0) begin
                        r_res_block <= r_cur + r_dsi;
                        r_res_rem   <= REM_W'(r_off & OFF_W'(BLOCK_BYTES - 1));
                        r_state     <= S_RESP;
                    end else begin
                        r_state <= S_SEEK_CHK;
                    end
                end
                S_SEEK_CHK: begin
                    if ((r_rdata == END_OF_CHAIN) || (r_rdata == '0)) begin
                        r_res_status <= ST_ENDED;
                        r_state      <= S_RESP;
                    end else if (rdata_oob) begin
                        r_res_status <= ST_RANGE;
                        r_state      <= S_RESP;
                    end else begin
                        r_cur   <= r_rdata;
                        r_steps <= r_steps - SCAN_W'(1);
                        r_state <= S_SEEK_RD;
                    end
                end

                // hand the result to the output register
                S_RESP: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_block  <= r_res_block;
                        r_out_rem    <= r_res_rem;
                        r_out_free   <= r_free;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_result_block     = r_out_block;
    assign o_remaining_offset = r_out_rem;
    assign o_free_blocks      = r_out_free;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FCM_ASSERT_NXT(a_busy_after_accept, i_valid && o_ready, r_state != S_IDLE, "accepted command did not start")
    `FCM_ASSERT_IMP(a_no_write_idle, mem_we, r_state != S_IDLE, "table written while idle")
    `FCM_ASSERT_IMP(a_result_from_resp, $rose(o_valid), $past(r_state) == S_RESP, "result raised outside response step")
    `FCM_ASSERT_IMP(a_free_bounded, (r_state == S_IDLE) && !r_dirty, SCAN_W'(r_free) <= lim, "free count above search limit")
    `FCM_ASSERT_IMP(a_scan_in_limit, (r_state == S_SCAN) && r_pend, SCAN_W'(r_chk) < lim, "scan checked an entry past the limit")

endmodule
